/* design/lcdfp_pkg.sv */
package lcdfp_pkg;

	// Request kinds carried in the mode field
	localparam logic [2:0] MODE_COMMAND = 3'd0;
	localparam logic [2:0] MODE_SINGLE  = 3'd1;
	localparam logic [2:0] MODE_BURST   = 3'd2;
	localparam logic [2:0] MODE_REFRESH = 3'd3;
	localparam logic [2:0] MODE_FILL    = 3'd4;

	// Frame identifiers, sent first on the wire
	localparam logic [2:0] ID_COMMAND = 3'b100;
	localparam logic [2:0] ID_WRITE   = 3'b101;

	localparam int RAM_DEPTH_DEF = 32;
	localparam int SEND_LIMIT    = 32;
	localparam int SEG_W         = 6;
	localparam logic [SEG_W-1:0] SEG_RESET = 6'd32;
	localparam int FRAME_ADDR_W  = 6;
	localparam int NIBBLE_W      = 4;
	localparam int CHUNK_W       = 12;
	localparam int BUF_W         = 20;
	localparam int QUEUE_DEPTH   = 2;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] command_code;
		logic [7:0] address;
		logic [7:0] value;
		logic       burst_first;
		logic       burst_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_end;
	} out_word_t;

	typedef enum logic [1:0] {
		HDR_NONE,
		HDR_CMD,
		HDR_WRITE
	} hdr_kind_t;

	// One classified request, handed from front to back
	typedef struct packed {
		logic                    clear;
		hdr_kind_t               hdr;
		logic [7:0]              hdr_arg;
		logic                    nib_en;
		logic [FRAME_ADDR_W-1:0] nib_addr;
		logic [NIBBLE_W-1:0]     nib_val;
		logic                    refresh;
		logic                    fill;
		logic                    finish;
	} op_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_START,
		B_HEAD,
		B_NIB,
		B_RD,
		B_SEND,
		B_FIN
	} back_state_t;

endpackage

/* design/lcdfp_front.sv */
module lcdfp_front import lcdfp_pkg::*; #(
	parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_data,
	output logic     op_push,
	output op_t      op,
	input  logic     queue_full
);

	localparam int BA_W = $clog2(RAM_DEPTH + 1);

	logic            dropped_q;
	logic [BA_W-1:0] baddr_q;
	logic            accept;
	logic            op_any;
	logic            first_in_range;
	logic            eff_dropped;
	logic [7:0]      eff_addr;
	logic            eff_in_range;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	// Resolve where a burst word lands
	assign first_in_range = in_data.address < 8'(RAM_DEPTH);
	assign eff_dropped    = in_data.burst_first ? !first_in_range : dropped_q;
	assign eff_addr       = in_data.burst_first ? in_data.address : 8'(baddr_q);
	assign eff_in_range   = eff_addr < 8'(RAM_DEPTH);

	// Classify the word into an operation for the back end
	always_comb begin
		op        = '0;
		op.hdr    = HDR_NONE;
		op_any    = 1'b0;
		op.nib_val = in_data.value[NIBBLE_W-1:0];
		unique case (in_data.mode)
			MODE_COMMAND: begin
				op.clear   = 1'b1;
				op.hdr     = HDR_CMD;
				op.hdr_arg = in_data.command_code;
				op.finish  = 1'b1;
				op_any     = 1'b1;
			end
			MODE_SINGLE: begin
				if (in_data.address < 8'(RAM_DEPTH)) begin
					op.clear    = 1'b1;
					op.hdr      = HDR_WRITE;
					op.hdr_arg  = in_data.address;
					op.nib_en   = 1'b1;
					op.nib_addr = in_data.address[FRAME_ADDR_W-1:0];
					op.finish   = 1'b1;
					op_any      = 1'b1;
				end
			end
			MODE_BURST: begin
				op.clear = in_data.burst_first;
				if (in_data.burst_first && first_in_range) begin
					op.hdr     = HDR_WRITE;
					op.hdr_arg = in_data.address;
				end
				if (!eff_dropped) begin
					op.nib_en   = eff_in_range;
					op.nib_addr = eff_addr[FRAME_ADDR_W-1:0];
					op.finish   = in_data.burst_last;
				end
				op_any = op.clear || op.nib_en || op.finish;
			end
			MODE_REFRESH: begin
				op.clear   = 1'b1;
				op.hdr     = HDR_WRITE;
				op.refresh = 1'b1;
				op.finish  = 1'b1;
				op_any     = 1'b1;
			end
			MODE_FILL: begin
				op.clear   = 1'b1;
				op.hdr     = HDR_WRITE;
				op.refresh = 1'b1;
				op.fill    = 1'b1;
				op.finish  = 1'b1;
				op_any     = 1'b1;
			end
			default: begin
				op_any = 1'b0;
			end
		endcase
	end

	assign op_push = accept && op_any;

	// Track the open burst: next address and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q <= 1'b0;
			baddr_q   <= '0;
		end else if (accept && in_data.mode == MODE_BURST) begin
			if (in_data.burst_first) begin
				dropped_q <= !first_in_range;
			end
			if (!eff_dropped && eff_in_range) begin
				baddr_q <= BA_W'(eff_addr + 8'd1);
			end
		end
	end

endmodule

/* design/lcdfp_queue.sv */
module lcdfp_queue import lcdfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  head_op,
	output logic not_empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	op_t           slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = count_q == CW'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_op   = slot_q[rd_ptr_q];

	// Store an incoming operation
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/lcdfp_back.sv */
module lcdfp_back import lcdfp_pkg::*; #(
	parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  op_t              op,
	input  logic             op_valid,
	output logic             op_pop,
	input  logic [SEG_W-1:0] segments_in_use,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_data
);

	localparam int AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
	localparam int LIM   = (RAM_DEPTH < SEND_LIMIT) ? RAM_DEPTH : SEND_LIMIT;
	localparam int CNT_W = $clog2(BUF_W + 1);
	localparam int LEN_W = $clog2(CHUNK_W + 1);

	back_state_t          state_q;
	back_state_t          state_d;
	op_t                  op_q;
	logic [SEG_W-1:0]     idx_q;
	logic [SEG_W-1:0]     send_n;
	logic [BUF_W-1:0]     buf_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	out_word_t            out_data_q;

	logic [NIBBLE_W-1:0]  ram [RAM_DEPTH];
	logic [RAM_DEPTH-1:0] vld_q;
	logic [NIBBLE_W-1:0]  rd_nib_q;
	logic                 rd_vld_q;

	logic                 push_req;
	logic [CHUNK_W-1:0]   chunk;
	logic [LEN_W-1:0]     len;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [NIBBLE_W-1:0]  ram_wdata;
	logic                 rd_en;
	logic                 clr_req;
	logic                 fin_req;
	logic [NIBBLE_W-1:0]  send_nib;

	logic                 out_free;
	logic                 pop;
	logic                 clr_ok;
	logic                 fin_ok;
	logic                 push_ok;
	logic [CNT_W-1:0]     cnt_pop;
	logic [BUF_W-1:0]     buf_pop;
	logic [BUF_W-1:0]     ins;
	logic [BUF_W-1:0]     buf_d;
	logic [CNT_W-1:0]     cnt_d;
	back_state_t          after_head;

	// Nibbles go out least significant bit first
	function automatic logic [NIBBLE_W-1:0] rev_nib(input logic [NIBBLE_W-1:0] v);
		logic [NIBBLE_W-1:0] r;
		for (int i = 0; i < NIBBLE_W; i++) begin
			r[i] = v[NIBBLE_W-1-i];
		end
		return r;
	endfunction

	assign send_n   = (segments_in_use > SEG_W'(LIM)) ? SEG_W'(LIM) : segments_in_use;
	assign send_nib = op_q.fill ? op_q.nib_val : (rd_vld_q ? rd_nib_q : '0);

	// Sequencer outputs
	always_comb begin
		push_req  = 1'b0;
		chunk     = '0;
		len       = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = op_q.nib_val;
		rd_en     = 1'b0;
		clr_req   = 1'b0;
		fin_req   = 1'b0;
		op_pop    = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				op_pop = op_valid;
			end
			B_START: begin
				clr_req = op_q.clear;
			end
			B_HEAD: begin
				unique case (op_q.hdr)
					HDR_CMD: begin
						push_req = 1'b1;
						chunk    = {ID_COMMAND, op_q.hdr_arg, 1'b0};
						len      = LEN_W'(12);
					end
					HDR_WRITE: begin
						push_req = 1'b1;
						chunk    = {3'b000, ID_WRITE, op_q.hdr_arg[FRAME_ADDR_W-1:0]};
						len      = LEN_W'(9);
					end
					default: begin
						push_req = 1'b0;
					end
				endcase
			end
			B_NIB: begin
				push_req  = 1'b1;
				chunk     = {8'b0, rev_nib(op_q.nib_val)};
				len       = LEN_W'(NIBBLE_W);
				ram_we    = push_ok;
				ram_waddr = op_q.nib_addr[AW-1:0];
			end
			B_RD: begin
				rd_en = (idx_q != send_n) && !op_q.fill;
			end
			B_SEND: begin
				push_req  = 1'b1;
				chunk     = {8'b0, rev_nib(send_nib)};
				len       = LEN_W'(NIBBLE_W);
				ram_we    = push_ok && op_q.fill;
				ram_waddr = idx_q[AW-1:0];
			end
			B_FIN: begin
				fin_req = 1'b1;
			end
			default: begin
				op_pop = 1'b0;
			end
		endcase
	end

	// Bit buffer: drain whole bytes, append chunks, clear at frame edges
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = out_free && (cnt_q >= CNT_W'(8));
	assign clr_ok   = clr_req && (cnt_q < CNT_W'(8));
	assign fin_ok   = fin_req && (cnt_q < CNT_W'(8)) && out_free;
	assign cnt_pop  = pop ? cnt_q - CNT_W'(8) : cnt_q;
	assign buf_pop  = pop ? {buf_q[BUF_W-9:0], 8'b0} : buf_q;
	assign push_ok  = push_req && (({1'b0, cnt_pop} + (CNT_W+1)'(len)) <= (CNT_W+1)'(BUF_W));
	assign ins      = ({chunk, 8'b0} << (LEN_W'(CHUNK_W) - len)) >> cnt_pop;

	always_comb begin
		if (clr_ok || fin_ok) begin
			buf_d = '0;
			cnt_d = '0;
		end else if (push_ok) begin
			buf_d = buf_pop | ins;
			cnt_d = cnt_pop + CNT_W'(len);
		end else begin
			buf_d = buf_pop;
			cnt_d = cnt_pop;
		end
	end

	// Next state
	always_comb begin
		if (op_q.nib_en) begin
			after_head = B_NIB;
		end else if (op_q.refresh) begin
			after_head = B_RD;
		end else if (op_q.finish) begin
			after_head = B_FIN;
		end else begin
			after_head = B_IDLE;
		end
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (op_valid) begin
					state_d = B_START;
				end
			end
			B_START: begin
				if (!op_q.clear || clr_ok) begin
					state_d = B_HEAD;
				end
			end
			B_HEAD: begin
				if (op_q.hdr == HDR_NONE || push_ok) begin
					state_d = after_head;
				end
			end
			B_NIB: begin
				if (push_ok) begin
					state_d = op_q.finish ? B_FIN : B_IDLE;
				end
			end
			B_RD: begin
				state_d = (idx_q == send_n) ? B_FIN : B_SEND;
			end
			B_SEND: begin
				if (push_ok) begin
					state_d = B_RD;
				end
			end
			B_FIN: begin
				if (fin_ok) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			buf_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			buf_q   <= buf_d;
			cnt_q   <= cnt_d;
			if (op_pop) begin
				idx_q <= '0;
			end else if (state_q == B_SEND && push_ok) begin
				idx_q <= idx_q + 1'b1;
			end
			if (fin_ok || pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[idx_q[AW-1:0]];
			end
		end
	end

	// Hold the current operation and the outgoing word
	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q <= op;
		end
		if (fin_ok) begin
			out_data_q <= '{tx_byte: buf_q[BUF_W-1:BUF_W-8], frame_end: 1'b1};
		end else if (pop) begin
			out_data_q <= '{tx_byte: buf_q[BUF_W-1:BUF_W-8], frame_end: 1'b0};
		end
	end

	// Shadow RAM, registered read
	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram[ram_waddr] <= ram_wdata;
		end
		if (rd_en) begin
			rd_nib_q <= ram[idx_q[AW-1:0]];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* design/lcd_controller_frame_packer.sv */
// Packs requests into serial frames for a 32x4 segment LCD controller and hands
// them out as bytes, first wire bit in bit 7; the last byte of each frame is
// zero padded and flagged with frame_end. A front end classifies each input
// word and queues it (two entries), so input words keep flowing while the back
// end packs until the queue fills. The back end handles one request at a time
// through its start, header, nibble, read, send and finish states; a refresh
// reads each sent shadow RAM entry and then packs it, while a fill packs its
// value and writes it into each sent entry. At most one byte leaves per cycle.
// The shadow RAM reads as zero after reset through per-entry valid flags, so
// no clearing pass is needed and requests are taken right away.
module lcd_controller_frame_packer import lcdfp_pkg::*; #(
	parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_data,
	input  logic             cfg_wr_en,
	input  logic [SEG_W-1:0] cfg_wr_data
);

	logic [SEG_W-1:0] seg_q;
	logic             q_push;
	op_t              q_in;
	logic             q_full;
	logic             q_pop;
	op_t              q_head;
	logic             q_not_empty;

	// Segment count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_RESET;
		end else if (cfg_wr_en) begin
			seg_q <= cfg_wr_data;
		end
	end

	lcdfp_front #(
		.RAM_DEPTH (RAM_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.op_push    (q_push),
		.op         (q_in),
		.queue_full (q_full)
	);

	lcdfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head_op   (q_head),
		.not_empty (q_not_empty)
	);

	lcdfp_back #(
		.RAM_DEPTH (RAM_DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (q_head),
		.op_valid        (q_not_empty),
		.op_pop          (q_pop),
		.segments_in_use (seg_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data)
	);

endmodule
